>>> sv/rlss_pkg.sv
// shared types, constants and helpers of the led strip serializer
`timescale 1ns / 1ps
package rlss_pkg;

   // pixel store geometry
   localparam int MAX_PIXELS = 256;
   localparam int PIX_AW     = $clog2(MAX_PIXELS);
   localparam int CNT_W      = 9;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS   = 3'd5;

   // register reset values
   localparam logic [8:0]  RST_LED_COUNT  = 9'd0;
   localparam logic [7:0]  RST_BRIGHTNESS = 8'd128;
   localparam logic [5:0]  RST_ZERO_HIGH  = 6'd3;
   localparam logic [5:0]  RST_ONE_HIGH   = 6'd9;
   localparam logic [5:0]  RST_BIT_PERIOD = 6'd12;
   localparam logic [15:0] RST_GAP_TICKS  = 16'd500;

   localparam logic [4:0]  BITS_PER_PIXEL = 5'd24;

   typedef enum logic [1:0] {
      ACT_TICK      = 2'd0,
      ACT_SET_PIXEL = 2'd1,
      ACT_SHOW      = 2'd2,
      ACT_RESERVED  = 2'd3
   } action_type;

   typedef logic [23:0] pixel_type;

   // floor(c * b / 255) for 8-bit operands
   function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] prod;
      logic [15:0] sum;
      prod = c * b;
      // largest product 65025 keeps the sum below 2^16
      sum  = prod + {8'd0, prod[15:8]} + 16'd1;
      return sum[15:8];
   endfunction

endpackage

>>> sv/rlss_req_if.sv
// request channel interface of the led strip serializer
`timescale 1ns / 1ps
interface rlss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, action, pixel_index, red, green, blue, input ready);
   modport sink (input valid, action, pixel_index, red, green, blue, output ready);
endinterface

>>> sv/rlss_rsp_if.sv
// response channel interface of the led strip serializer
`timescale 1ns / 1ps
interface rlss_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic rejected;
   logic frame_done;

   modport source (output valid, line_level, busy_res, rejected, frame_done, input ready);
   modport sink (input valid, line_level, busy_res, rejected, frame_done, output ready);
endinterface

>>> sv/rgb_led_strip_serializer_top.sv
// top level of the single-wire rgb led strip serializer
//
//   channel  dir  handshake       contents
//   req_ch   in   valid / ready   action, pixel_index, red, green, blue
//   rsp_ch   out  valid / ready   line_level, busy_res, rejected, frame_done
//   csr_*    in   csr_we only     csr_index, csr_wdata (write only)
//
// one item per clock while rsp_ch does not stall, every item answers with exactly one item on rsp_ch
// the rsp register is a one-deep pipeline stage: req_ch is ready whenever
// that stage is empty or drained in the same cycle, so a stall on rsp_ch
// holds req_ch for as long as it lasts
// pixel data sits in a 256 x 24 memory with registered read; the word for the
// next pixel is prefetched while the current one shifts out
// synchronous reset clears all control state and the per-entry valid bits,
// so an entry never written reads as zero with no clearing pass
`timescale 1ns / 1ps
module rgb_led_strip_serializer_top (
   input  logic                              clock,
   input  logic                              reset,
   rlss_req_if.sink                          req_ch,
   rlss_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [rlss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rlss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rlss_pkg::*;

   // configuration registers
   logic [8:0]  led_count_ff;
   logic [7:0]  brightness_ff;
   logic [5:0]  zero_high_ff;
   logic [5:0]  one_high_ff;
   logic [5:0]  bit_period_ff;
   logic [15:0] gap_ticks_ff;

   // frame state
   logic              sending_ff,   sending_in;
   logic              gap_phase_ff, gap_phase_in;
   logic [PIX_AW-1:0] pix_pos_ff,   pix_pos_in;
   logic [4:0]        bit_pos_ff,   bit_pos_in;
   logic [15:0]       tick_ff,      tick_in;
   pixel_type         shift_ff,     shift_in;
   pixel_type         pix0_ff,      pix0_in;

   // pixel memory with one valid bit per entry
   pixel_type         pixel_mem [MAX_PIXELS];
   logic [MAX_PIXELS-1:0] entry_valid_ff;
   logic              mem_we;
   logic [PIX_AW-1:0] mem_waddr;
   pixel_type         mem_wdata;
   logic [PIX_AW-1:0] mem_raddr;
   pixel_type         rd_data_ff;
   logic              rd_valid_ff;
   pixel_type         next_word;

   // response stage
   logic rsp_valid_ff, rsp_valid_in;
   logic level_ff,  level_in;
   logic busy_ff,   busy_in;
   logic rej_ff,    rej_in;
   logic done_ff,   done_in;

   logic       accept;
   action_type act;
   logic [8:0] eff_count;
   logic [16:0] tick_p1;
   logic [5:0] high_ticks;
   logic [4:0] bit_p1;
   logic [8:0] pos_p1;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign act          = action_type'(req_ch.action);

   // counts above the store size act as the store size
   assign eff_count = (led_count_ff > 9'(MAX_PIXELS)) ? 9'(MAX_PIXELS) : led_count_ff;

   assign tick_p1    = {1'b0, tick_ff} + 17'd1;
   assign high_ticks = shift_ff[23] ? one_high_ff : zero_high_ff;
   assign bit_p1     = bit_pos_ff + 5'd1;
   assign pos_p1     = {1'b0, pix_pos_ff} + 9'd1;

   // prefetch always looks one pixel ahead; store is frozen during a frame
   assign mem_raddr = pix_pos_ff + PIX_AW'(1);
   assign next_word = rd_valid_ff ? rd_data_ff : '0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff  <= RST_LED_COUNT;
         brightness_ff <= RST_BRIGHTNESS;
         zero_high_ff  <= RST_ZERO_HIGH;
         one_high_ff   <= RST_ONE_HIGH;
         bit_period_ff <= RST_BIT_PERIOD;
         gap_ticks_ff  <= RST_GAP_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LED_COUNT:  led_count_ff  <= csr_wdata[8:0];
            CSR_BRIGHTNESS: brightness_ff <= csr_wdata[7:0];
            CSR_ZERO_HIGH:  zero_high_ff  <= csr_wdata[5:0];
            CSR_ONE_HIGH:   one_high_ff   <= csr_wdata[5:0];
            CSR_BIT_PERIOD: bit_period_ff <= csr_wdata[5:0];
            CSR_GAP_TICKS:  gap_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item processing: next state, memory write and response
   always_comb begin
      sending_in   = sending_ff;
      gap_phase_in = gap_phase_ff;
      pix_pos_in   = pix_pos_ff;
      bit_pos_in   = bit_pos_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      pix0_in      = pix0_ff;
      mem_we       = 1'b0;
      mem_waddr    = req_ch.pixel_index[PIX_AW-1:0];
      mem_wdata    = {scale_color(req_ch.green, brightness_ff),
                      scale_color(req_ch.red, brightness_ff),
                      scale_color(req_ch.blue, brightness_ff)};
      level_in     = level_ff;
      busy_in      = busy_ff;
      rej_in       = rej_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         level_in     = 1'b0;
         busy_in      = sending_ff;
         rej_in       = 1'b0;
         done_in      = 1'b0;
         case (act)
            ACT_TICK: begin
               if (sending_ff && gap_phase_ff) begin
                  // latch gap
                  if (tick_p1 >= {1'b0, gap_ticks_ff}) begin
                     sending_in   = 1'b0;
                     gap_phase_in = 1'b0;
                     tick_in      = '0;
                     done_in      = 1'b1;
                  end else begin
                     tick_in = tick_p1[15:0];
                  end
               end else if (sending_ff) begin
                  level_in = (tick_ff < {10'd0, high_ticks});
                  if (tick_p1 >= {11'd0, bit_period_ff}) begin
                     // end of bit
                     tick_in    = '0;
                     shift_in   = {shift_ff[22:0], 1'b0};
                     bit_pos_in = bit_p1;
                     if (bit_p1 >= BITS_PER_PIXEL) begin
                        bit_pos_in = '0;
                        if (pos_p1 >= eff_count) begin
                           gap_phase_in = 1'b1;
                        end else begin
                           pix_pos_in = pos_p1[PIX_AW-1:0];
                           shift_in   = next_word;
                        end
                     end
                  end else begin
                     tick_in = tick_p1[15:0];
                  end
               end
            end
            ACT_SET_PIXEL: begin
               if (sending_ff || ({1'b0, req_ch.pixel_index} >= eff_count)) begin
                  rej_in = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  // pixel zero is shadowed so a frame can start at once
                  if (req_ch.pixel_index == 8'd0) begin
                     pix0_in = mem_wdata;
                  end
               end
            end
            ACT_SHOW: begin
               if (sending_ff || (eff_count == 9'd0)) begin
                  rej_in = 1'b1;
               end else begin
                  sending_in   = 1'b1;
                  gap_phase_in = 1'b0;
                  pix_pos_in   = '0;
                  bit_pos_in   = '0;
                  tick_in      = '0;
                  shift_in     = pix0_ff;
                  busy_in      = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // control and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         gap_phase_ff <= 1'b0;
         pix_pos_ff   <= '0;
         bit_pos_ff   <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         pix0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sending_ff   <= sending_in;
         gap_phase_ff <= gap_phase_in;
         pix_pos_ff   <= pix_pos_in;
         bit_pos_ff   <= bit_pos_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         pix0_ff      <= pix0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      level_ff <= level_in;
      busy_ff  <= busy_in;
      rej_ff   <= rej_in;
      done_ff  <= done_in;
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (mem_we) begin
            entry_valid_ff[mem_waddr] <= 1'b1;
         end
         rd_valid_ff <= entry_valid_ff[mem_raddr];
      end
   end

   // pixel memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pixel_mem[mem_raddr];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.line_level = level_ff;
   assign rsp_ch.busy_res   = busy_ff;
   assign rsp_ch.rejected   = rej_ff;
   assign rsp_ch.frame_done = done_ff;

   // checks
   a_gap_needs_frame: assert property (@(posedge clock) disable iff (reset)
      gap_phase_ff |-> sending_ff)
      else $error("gap phase outside a frame");

   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff < BITS_PER_PIXEL)
      else $error("bit position out of range");

   a_no_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !sending_ff)
      else $error("pixel store written during a frame");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> !sending_ff && rsp_ch.busy_res)
      else $error("frame done without frame end");

   a_level_only_in_bits: assert property (@(posedge clock) disable iff (reset)
      (accept && level_in) |-> sending_ff && !gap_phase_ff)
      else $error("line high outside a bit");

endmodule
